// File: rtl/windowed_min_max_logger_defines.svh
// Assertion macros for the windowed min/max logger.
`ifndef WINDOWED_MIN_MAX_LOGGER_DEFINES_SVH
`define WINDOWED_MIN_MAX_LOGGER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define WMM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("windowed_min_max_logger: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define WMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("windowed_min_max_logger: next-cycle check failed");
`else
`define WMM_ASSERT_IMPL(label, ante, cons)
`define WMM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/wmm_pkg.sv
// Shared types and constants for the windowed min/max logger.
`timescale 1ns / 1ps

package wmm_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FILL_OUT_W = 5;

  // Action codes of an input transaction
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  // Cached values before any find, and after a find on an empty ring
  localparam logic signed [DATA_W-1:0] HIGH_SENTINEL = 16'sh8000;
  localparam logic signed [DATA_W-1:0] LOW_SENTINEL  = 16'sh7FFF;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
  } wmm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_min;
    logic signed [DATA_W-1:0] window_max;
    logic [FILL_OUT_W-1:0]    filled_count;
  } wmm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } wmm_state_e;

endpackage

// File: rtl/wmm_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module wmm_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 24,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/windowed_min_max_logger.sv
// Top level of the windowed min/max logger: ring of interval extremes with a scan engine.
//
//  channel | direction | payload  | handshake
//  --------+-----------+----------+------------------------
//  in      | input     | wmm_in_t | in_valid_i / in_stall_o
//  out     | output    | wmm_out_t| out_valid_o / out_stall_i
//
// A push, or a find on an empty ring, loads the result register straight from idle.
// A find on a non-empty ring scans: one entry per cycle from the single read port of
// each store, then a drain state for the read latency and a finish state that loads
// the result once the result register is free; the next transaction is taken in idle.
// Reset clears slot, fill count and cached extremes; the stores need no clearing.
// A new transaction is taken only in idle while the result register is empty or being drained.
`timescale 1ns / 1ps
`include "windowed_min_max_logger_defines.svh"

module windowed_min_max_logger #(
  parameter int unsigned WINDOW_DEPTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wmm_pkg::wmm_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wmm_pkg::wmm_out_t out_o
);

  import wmm_pkg::*;

  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);

  wmm_state_e state_q, state_d;

  logic [ADDR_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic              rd_pend_q, rd_first_q;

  logic signed [DATA_W-1:0] cached_hi_q, cached_hi_d;
  logic signed [DATA_W-1:0] cached_lo_q, cached_lo_d;
  logic signed [DATA_W-1:0] hi_acc_q, lo_acc_q;
  logic signed [DATA_W-1:0] hi_rd, lo_rd;

  wmm_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;

  logic in_acc, out_free, ram_wr_en, ram_rd_en;
  logic push_grow;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Push accepted while the ring still has room
  assign push_grow = in_acc && (in_i.action == ACT_PUSH) && (fill_q < CNT_W'(WINDOW_DEPTH));

  // Ring stores: interval maxima and interval minima
  wmm_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_high_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (in_i.max_value),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (hi_rd)
  );

  wmm_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_low_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (in_i.min_value),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (lo_rd)
  );

  // Next state, store control and result loading
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    rd_addr_d   = rd_addr_q;
    cached_hi_d = cached_hi_q;
    cached_lo_d = cached_lo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.action == ACT_PUSH) begin
            ram_wr_en = 1'b1;
            slot_d    = (slot_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : ADDR_W'(slot_q + 1'b1);
            if (fill_q < CNT_W'(WINDOW_DEPTH)) begin
              fill_d = CNT_W'(fill_q + 1'b1);
            end
            out_d       = '{window_min: cached_lo_q, window_max: cached_hi_q,
                            filled_count: FILL_OUT_W'(fill_d)};
            out_valid_d = 1'b1;
          end else if (fill_q == '0) begin
            // Empty ring: fall back to the sentinels
            cached_hi_d = HIGH_SENTINEL;
            cached_lo_d = LOW_SENTINEL;
            out_d       = '{window_min: LOW_SENTINEL, window_max: HIGH_SENTINEL,
                            filled_count: FILL_OUT_W'(fill_q)};
            out_valid_d = 1'b1;
          end else begin
            rd_addr_d = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle over slots 0 .. fill-1
        ram_rd_en = 1'b1;
        rd_addr_d = ADDR_W'(rd_addr_q + 1'b1);
        if (CNT_W'(CNT_W'(rd_addr_q) + 1'b1) == fill_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cached_hi_d = hi_acc_q;
          cached_lo_d = lo_acc_q;
          out_d       = '{window_min: lo_acc_q, window_max: hi_acc_q,
                          filled_count: FILL_OUT_W'(fill_q)};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      rd_addr_q   <= '0;
      rd_pend_q   <= 1'b0;
      rd_first_q  <= 1'b0;
      cached_hi_q <= HIGH_SENTINEL;
      cached_lo_q <= LOW_SENTINEL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      rd_addr_q   <= rd_addr_d;
      rd_pend_q   <= ram_rd_en;
      rd_first_q  <= ram_rd_en && (rd_addr_q == '0);
      cached_hi_q <= cached_hi_d;
      cached_lo_q <= cached_lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload and running extremes
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (rd_pend_q) begin
      if (rd_first_q || (hi_rd > hi_acc_q)) begin
        hi_acc_q <= hi_rd;
      end
      if (rd_first_q || (lo_rd < lo_acc_q)) begin
        lo_acc_q <= lo_rd;
      end
    end
  end

  // Checks
  `WMM_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_q <= CNT_W'(WINDOW_DEPTH))
  `WMM_ASSERT_IMPL(a_slot_bounded, 1'b1, slot_q <= ADDR_W'(WINDOW_DEPTH - 1))
  `WMM_ASSERT_IMPL(a_scan_in_fill, state_q == ST_SCAN, CNT_W'(rd_addr_q) < fill_q)
  `WMM_ASSERT_NEXT(a_push_grows, push_grow, fill_q == CNT_W'($past(fill_q) + 1'b1))

endmodule
